// ===== rtl/fms_pkg.sv =====
// ============================================================================
// fms_pkg : shared types and constants for the FFT magnitude spectrum unit
// Holds the work-word and twiddle widths, the sequencer state type and the
// quarter-wave sine table used to build the radix-2 twiddle factors.
// ============================================================================
package fms_pkg;

    localparam int DEF_POINTS   = 128;
    localparam int TABLE_POINTS = 128;
    localparam int WORD_W       = 24;
    localparam int SAMPLE_W     = 16;
    localparam int TW_W         = 17;
    localparam int BIN_W        = 6;
    localparam int MAG_W        = 24;
    localparam int ADDR_W       = 7;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_BF_RD,
        ST_BF_MUL,
        ST_BF_ADD,
        ST_BF_WR,
        ST_MG_RD,
        ST_MG_SQ,
        ST_MG_ADD,
        ST_MG_ROOT,
        ST_MG_OUT
    } t_state;

    // round(32768 * sin(pi*k/64)), k = 0..32
    function automatic logic [TW_W-1:0] quarter_sine(input logic [5:0] k);
        logic [TW_W-1:0] v;
        case (k)
            6'd0:  v = 17'd0;     6'd1:  v = 17'd1608;  6'd2:  v = 17'd3212;
            6'd3:  v = 17'd4808;  6'd4:  v = 17'd6393;  6'd5:  v = 17'd7962;
            6'd6:  v = 17'd9512;  6'd7:  v = 17'd11039; 6'd8:  v = 17'd12540;
            6'd9:  v = 17'd14010; 6'd10: v = 17'd15447; 6'd11: v = 17'd16846;
            6'd12: v = 17'd18205; 6'd13: v = 17'd19520; 6'd14: v = 17'd20788;
            6'd15: v = 17'd22006; 6'd16: v = 17'd23170; 6'd17: v = 17'd24279;
            6'd18: v = 17'd25330; 6'd19: v = 17'd26320; 6'd20: v = 17'd27246;
            6'd21: v = 17'd28106; 6'd22: v = 17'd28899; 6'd23: v = 17'd29622;
            6'd24: v = 17'd30274; 6'd25: v = 17'd30853; 6'd26: v = 17'd31357;
            6'd27: v = 17'd31786; 6'd28: v = 17'd32138; 6'd29: v = 17'd32413;
            6'd30: v = 17'd32610; 6'd31: v = 17'd32729; 6'd32: v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/fft_magnitude_spectrum_unit.sv =====
// ============================================================================
// fft_magnitude_spectrum_unit : fixed-point radix-2 FFT magnitude spectrum
// ----------------------------------------------------------------------------
// Input stream: one signed 16-bit real sample per transfer (s_axis_tdata).
// Samples are written to the work memory at bit-reversed addresses. The
// transfer that completes a frame of POINTS samples starts the transform.
// Load takes one sample per cycle while s_axis_tvalid is high. Then the
// sequencer runs log2(POINTS)*POINTS/2 butterflies, each through the read,
// multiply, add and write states on one shared complex multiplier and one
// memory port pair. It then emits POINTS/2 bins, each computed by a shared
// pair of squarers and a bit-serial square root of 24 steps, plus output wait.
// Output stream: tdata = bin[5:0], magnitude[29:6]; tlast marks the final bin.
// The unit accepts no sample while transforming or emitting; a stalled
// receiver holds the current bin in the output register.
// Reset (synchronous, active low) clears the sample count and the sequencer;
// the work memory needs no clearing since every frame writes it fully first.
// ============================================================================
module fft_magnitude_spectrum_unit #(
    parameter int POINTS = fms_pkg::DEF_POINTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [5:0] bin, [29:6] magnitude, zero pad
    output logic        m_axis_tlast
);
    import fms_pkg::*;

    localparam int LOGN = $clog2(POINTS);
    localparam int AW   = (LOGN < 2) ? 2 : LOGN;
    localparam int SW   = $clog2(LOGN + 1);
    localparam int TSH  = ADDR_W - LOGN;        // table stride shift
    localparam int NB   = POINTS / 2;
    localparam int PW_W = 2 * WORD_W;           // power width, even for the root
    localparam int RT_W = (PW_W + 1) / 2;       // root width
    localparam int RSTEPS = RT_W;

    // work memory
    logic signed [WORD_W-1:0] mem_re [POINTS];
    logic signed [WORD_W-1:0] mem_im [POINTS];

    t_state r_state, n_state;
    logic [AW-1:0]  r_cnt, n_cnt;         // sample count / butterfly index
    logic [SW-1:0]  r_stage, n_stage;     // butterfly stage (half = 1<<stage)
    logic [AW-1:0]  r_bin, n_bin;
    logic [5:0]     r_step, n_step;

    // memory ports
    logic [AW-1:0]  rd_a, rd_b, wr_a, wr_b;
    logic           we_load, we_bf;
    logic signed [WORD_W-1:0] r_ar, r_ai, r_br, r_bi;

    // butterfly datapath registers
    logic signed [TW_W-1:0]   r_c, r_s;
    logic signed [41:0]       r_p0, r_p1, r_p2, r_p3;
    logic signed [WORD_W-1:0] r_tr, r_ti;
    logic signed [WORD_W-1:0] r_ar2, r_ai2;

    // magnitude datapath registers
    logic [PW_W-1:0] r_pw, r_rem;
    logic [RT_W-1:0] r_root;
    logic [2*WORD_W-1:0] r_sq_re, r_sq_im;
    logic            r_ovalid;
    logic [BIN_W-1:0] r_obin;
    logic [MAG_W-1:0] r_omag;
    logic            r_olast;

    // bit reverse of the load address
    logic [AW-1:0] rev_idx;
    always_comb begin
        rev_idx = '0;
        for (int b = 0; b < LOGN; b++) rev_idx[LOGN-1-b] = r_cnt[b];
    end

    // butterfly addressing: insert a zero at bit 'stage' of the index
    logic [AW-1:0] half, lowmask, bf_a, bf_b, jpos;
    logic [ADDR_W-1:0] tw_idx;
    always_comb begin
        half    = AW'(1) << r_stage;
        lowmask = half - AW'(1);
        bf_a    = ((r_cnt & ~lowmask) << 1) | (r_cnt & lowmask);
        bf_b    = bf_a | half;
        jpos    = r_cnt & lowmask;
        tw_idx  = ADDR_W'(ADDR_W'(jpos) << (ADDR_W'(TSH) + ADDR_W'(LOGN - 1) - ADDR_W'(r_stage)));
    end

    // twiddle lookup: cos and sin of 2*pi*j/128, j in 0..63
    logic [5:0] tj;
    logic signed [TW_W-1:0] tw_c, tw_s;
    always_comb begin
        tj = tw_idx[5:0];
        if (tj <= 6'd32) begin
            tw_c = quarter_sine(6'd32 - tj);
            tw_s = quarter_sine(tj);
        end else begin
            tw_c = -quarter_sine(tj - 6'd32);
            tw_s = quarter_sine(6'd0 - tj);
        end
    end

    // rounding of the rotated products: floor((v + 16384) / 32768)
    logic signed [42:0] sum_r, sum_i;
    always_comb begin
        // wc = c, ws = -s
        sum_r = 43'(r_p0) + 43'(r_p1) + 43'sd16384;   // br*c + bi*s
        sum_i = 43'(r_p3) - 43'(r_p2) + 43'sd16384;   // bi*c - br*s
    end

    assign rd_a = (r_state == ST_MG_RD) ? r_bin : bf_a;
    assign rd_b = bf_b;
    assign wr_a = (r_state == ST_LOAD) ? rev_idx : bf_a;
    assign wr_b = bf_b;
    assign we_load = (r_state == ST_LOAD) && s_axis_tvalid;
    assign we_bf   = (r_state == ST_BF_WR);

    // memory access
    always_ff @(posedge i_clk) begin
        if (we_load) begin
            mem_re[wr_a] <= WORD_W'(signed'(s_axis_tdata));
            mem_im[wr_a] <= '0;
        end else if (we_bf) begin
            mem_re[wr_a] <= r_ar2;
            mem_im[wr_a] <= r_ai2;
            mem_re[wr_b] <= r_ar - r_tr;
            mem_im[wr_b] <= r_ai - r_ti;
        end
        r_ar <= mem_re[rd_a];
        r_ai <= mem_im[rd_a];
        r_br <= mem_re[rd_b];
        r_bi <= mem_im[rd_b];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_c <= tw_c;
        r_s <= tw_s;
        case (r_state)
            ST_BF_MUL: begin
                r_p0 <= 42'(r_br * r_c);
                r_p1 <= 42'(r_bi * r_s);
                r_p2 <= 42'(r_br * r_s);
                r_p3 <= 42'(r_bi * r_c);
            end
            ST_BF_ADD: begin
                r_tr  <= WORD_W'(sum_r >>> 15);
                r_ti  <= WORD_W'(sum_i >>> 15);
            end
            ST_MG_SQ: begin
                r_sq_re <= 48'(r_ar * r_ar);
                r_sq_im <= (r_bin == '0) ? '0 : 48'(r_ai * r_ai);
            end
            ST_MG_ADD: begin
                r_pw   <= PW_W'(r_sq_re) + PW_W'(r_sq_im);
                r_rem  <= '0;
                r_root <= '0;
            end
            ST_MG_ROOT: begin
                // restoring square root, two bits of radicand per step
                logic [PW_W+1:0] trial;
                logic [PW_W+1:0] rem2;
                rem2  = {r_rem[PW_W-1:0], r_pw[PW_W-1 -: 2]};
                trial = {r_root, 2'b01};
                if (rem2 >= trial) begin
                    r_rem  <= PW_W'(rem2 - trial);
                    r_root <= {r_root[RT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= PW_W'(rem2);
                    r_root <= {r_root[RT_W-2:0], 1'b0};
                end
                r_pw <= {r_pw[PW_W-3:0], 2'b00};
            end
            default: ;
        endcase
        if (r_state == ST_BF_ADD) begin
            r_ar2 <= r_ar + WORD_W'(sum_r >>> 15);
            r_ai2 <= r_ai + WORD_W'(sum_i >>> 15);
        end
    end

    // output register
    logic [RT_W:0] mag2;
    assign mag2 = {r_root, 1'b0};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_MG_OUT && !r_ovalid) begin
            r_ovalid <= 1'b1;
            r_obin   <= BIN_W'(r_bin);
            r_omag   <= (mag2 > (RT_W+1)'(24'hFFFFFF)) ? 24'hFFFFFF : MAG_W'(mag2);
            r_olast  <= (r_bin == AW'(NB - 1));
        end else if (r_ovalid && m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_stage <= '0;
            r_bin   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_stage <= n_stage;
            r_bin   <= n_bin;
            r_step  <= n_step;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_stage = r_stage;
        n_bin   = r_bin;
        n_step  = r_step;
        case (r_state)
            ST_LOAD: begin
                if (s_axis_tvalid) begin
                    if (r_cnt == AW'(POINTS - 1)) begin
                        n_cnt   = '0;
                        n_stage = '0;
                        n_state = ST_BF_RD;
                    end else begin
                        n_cnt = r_cnt + AW'(1);
                    end
                end
            end
            ST_BF_RD:  n_state = ST_BF_MUL;
            ST_BF_MUL: n_state = ST_BF_ADD;
            ST_BF_ADD: n_state = ST_BF_WR;
            ST_BF_WR: begin
                n_state = ST_BF_RD;
                if (r_cnt == AW'(NB - 1)) begin
                    n_cnt = '0;
                    if (r_stage == SW'(LOGN - 1)) begin
                        n_stage = '0;
                        n_bin   = '0;
                        n_state = ST_MG_RD;
                    end else begin
                        n_stage = r_stage + SW'(1);
                    end
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            ST_MG_RD:  n_state = ST_MG_SQ;
            ST_MG_SQ:  n_state = ST_MG_ADD;
            ST_MG_ADD: begin
                n_step  = '0;
                n_state = ST_MG_ROOT;
            end
            ST_MG_ROOT: begin
                n_step = r_step + 6'd1;
                if (r_step == 6'(RSTEPS - 1)) n_state = ST_MG_OUT;
            end
            ST_MG_OUT: begin
                if (!r_ovalid) begin
                    if (r_bin == AW'(NB - 1)) begin
                        n_bin   = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_bin   = r_bin + AW'(1);
                        n_state = ST_MG_RD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    assign s_axis_tready = (r_state == ST_LOAD);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_omag, r_obin};
    assign m_axis_tlast  = r_olast;

    // checks
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_LOAD) |-> !s_axis_tready) else $error("ready while busy");
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_last_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[5:0] == 6'(NB - 1)))
        else $error("last on wrong bin");

endmodule
